// ----- rtl/core/scan_disk_scheduler_top_macros.svh -----
// assertion macros shared by the checker
`ifndef SCAN_DISK_SCHEDULER_TOP_MACROS_SVH
`define SCAN_DISK_SCHEDULER_TOP_MACROS_SVH

// checked only outside reset
`define SDS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sds assertion failed");

// checked in every cycle, reset included
`define SDS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sds assertion failed");

`endif

// ----- rtl/core/sds_pkg.sv -----
package sds_pkg;

    localparam int MAX_REQUESTS = 32;

    localparam int CYL_W   = 16;
    localparam int CYLS_W  = 17;
    localparam int DIST_W  = 16;
    localparam int TOTAL_W = 22;
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [KIND_W-1:0] KIND_REQ    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOMOVE = 2'd2;

    localparam logic REG_HEAD = 1'b0;
    localparam logic REG_CYLS = 1'b1;

    typedef struct packed {
        logic [CYL_W-1:0] head;
        logic [CYL_W-1:0] end_stop;
    } t_cfg;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ----- rtl/core/sds_regs.sv -----
module sds_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sds_pkg::ADDR_W-1:0]    paddr,
    input  logic [sds_pkg::DATA_W-1:0]    pwdata,
    output logic [sds_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output sds_pkg::t_cfg                 o_cfg
);

    logic [sds_pkg::CYL_W-1:0]  r_head;
    logic [sds_pkg::CYLS_W-1:0] r_cyls;
    logic                       wr;
    logic                       idx;

    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cyls <= sds_pkg::CYLS_W'(65536);
        end else if (wr) begin
            unique case (idx)
                sds_pkg::REG_HEAD: r_head <= pwdata[sds_pkg::CYL_W-1:0];
                sds_pkg::REG_CYLS: r_cyls <= pwdata[sds_pkg::CYLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            sds_pkg::REG_HEAD: prdata = sds_pkg::DATA_W'(r_head);
            sds_pkg::REG_CYLS: prdata = sds_pkg::DATA_W'(r_cyls);
            default:           prdata = '0;
        endcase
    end

    // end stop with zero and oversized cylinder counts clamped
    always_comb begin
        o_cfg.head = r_head;
        if (r_cyls == '0) begin
            o_cfg.end_stop = '0;
        end else if (r_cyls[sds_pkg::CYLS_W-1]) begin
            o_cfg.end_stop = '1;
        end else begin
            o_cfg.end_stop = r_cyls[sds_pkg::CYL_W-1:0] - 1'b1;
        end
    end

endmodule

// ----- rtl/core/sds_store.sv -----
module sds_store #(
    parameter int DEPTH = sds_pkg::MAX_REQUESTS,
    parameter int AW    = 5
) (
    input  logic                      i_clk,
    input  sds_pkg::t_mem_ctl         i_ctl,
    input  logic [AW-1:0]             i_rd_addr,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [sds_pkg::CYL_W-1:0] i_wr_data,
    output logic [sds_pkg::CYL_W-1:0] o_rd_data
);

    logic [sds_pkg::CYL_W-1:0] r_mem [DEPTH];
    logic [sds_pkg::CYL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/sds_seq.sv -----
module sds_seq #(
    parameter int MAX_REQ = sds_pkg::MAX_REQUESTS,
    parameter int AW      = 5,
    parameter int CW      = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [sds_pkg::CYL_W-1:0]   i_cylinder,
    input  sds_pkg::t_cfg               i_cfg,
    output sds_pkg::t_mem_ctl           o_mem_ctl,
    output logic [AW-1:0]               o_rd_addr,
    output logic [AW-1:0]               o_wr_addr,
    output logic [sds_pkg::CYL_W-1:0]   o_wr_data,
    input  logic [sds_pkg::CYL_W-1:0]   i_rd_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [sds_pkg::CYL_W-1:0]   o_visited_cylinder,
    output logic [sds_pkg::DIST_W-1:0]  o_move_distance,
    output logic [sds_pkg::TOTAL_W-1:0] o_total_seek,
    output logic [sds_pkg::KIND_W-1:0]  o_kind,
    output logic                        o_dropped,
    output logic                        o_last
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS      = 3'd1;
    localparam logic [2:0] S_INS_LAST = 3'd2;
    localparam logic [2:0] S_ASC      = 3'd3;
    localparam logic [2:0] S_END      = 3'd4;
    localparam logic [2:0] S_DESC     = 3'd5;
    localparam logic [2:0] S_FIN      = 3'd6;

    logic [2:0]                  r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_ovf, n_ovf;
    logic [sds_pkg::CYL_W-1:0]   r_val, n_val;
    logic [AW-1:0]               r_idx, n_idx;
    logic [sds_pkg::CYL_W-1:0]   r_cur, n_cur;
    logic [sds_pkg::TOTAL_W-1:0] r_total, n_total;
    logic                        r_low, n_low;
    logic                        r_any, n_any;

    logic                        r_ovalid;
    logic [sds_pkg::CYL_W-1:0]   r_ocyl, n_ocyl;
    logic [sds_pkg::DIST_W-1:0]  r_odist, n_odist;
    logic [sds_pkg::TOTAL_W-1:0] r_ototal, n_ototal;
    logic [sds_pkg::KIND_W-1:0]  r_okind, n_okind;
    logic                        r_olast, n_olast;
    logic                        r_odrop;

    logic                        load_out;
    logic                        out_free;
    logic                        go_next;
    logic                        emit;
    logic                        low_now;
    logic                        last_idx;
    logic [CW-1:0]               count_m1_full;
    logic [AW-1:0]               count_m1;
    logic [sds_pkg::CYL_W-1:0]   tgt;
    logic [sds_pkg::DIST_W-1:0]  move_dist;
    logic [sds_pkg::TOTAL_W-1:0] total_next;

    assign out_free      = !r_ovalid || !i_stall;
    assign o_stall       = (r_state != S_IDLE);
    assign count_m1_full = r_count - 1'b1;
    assign count_m1      = count_m1_full[AW-1:0];
    assign last_idx      = (r_idx == count_m1);
    assign tgt           = (r_state == S_END) ? i_cfg.end_stop : i_rd_data;
    assign move_dist     = (tgt >= r_cur) ? (tgt - r_cur) : (r_cur - tgt);
    assign total_next    = r_total + sds_pkg::TOTAL_W'(move_dist);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_val     = r_val;
        n_idx     = r_idx;
        n_cur     = r_cur;
        n_total   = r_total;
        n_low     = r_low;
        n_any     = r_any;
        o_mem_ctl = '0;
        o_rd_addr = '0;
        o_wr_addr = '0;
        o_wr_data = r_val;
        load_out  = 1'b0;
        n_ocyl    = i_rd_data;
        n_odist   = move_dist;
        n_ototal  = total_next;
        n_okind   = sds_pkg::KIND_REQ;
        n_olast   = 1'b0;
        go_next   = 1'b0;
        emit      = 1'b0;
        low_now   = r_low;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_op) begin
                        if (r_count == CW'(MAX_REQ)) begin
                            n_ovf = 1'b1;
                        end else if (r_count == '0) begin
                            o_mem_ctl.wr_en = 1'b1;
                            o_wr_data       = i_cylinder;
                            n_count         = r_count + 1'b1;
                        end else begin
                            n_val           = i_cylinder;
                            n_idx           = count_m1;
                            o_mem_ctl.rd_en = 1'b1;
                            o_rd_addr       = count_m1;
                            n_state         = S_INS;
                        end
                    end else begin
                        n_cur   = i_cfg.head;
                        n_total = '0;
                        n_low   = 1'b0;
                        n_any   = 1'b0;
                        if (r_count == '0) begin
                            n_state = S_END;
                        end else begin
                            o_mem_ctl.rd_en = 1'b1;
                            n_idx           = '0;
                            n_state         = S_ASC;
                        end
                    end
                end
            end
            // shift larger entries up one place while walking down
            S_INS: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_idx + 1'b1;
                if (i_rd_data > r_val) begin
                    o_wr_data = i_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_INS_LAST;
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = r_idx - 1'b1;
                        n_idx           = r_idx - 1'b1;
                    end
                end else begin
                    o_wr_data = r_val;
                    n_count   = r_count + 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_INS_LAST: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_data       = r_val;
                n_count         = r_count + 1'b1;
                n_state         = S_IDLE;
            end
            S_ASC: begin
                emit    = (i_rd_data >= i_cfg.head);
                low_now = (r_idx == '0) ? !emit : r_low;
                n_low   = low_now;
                if (!emit || out_free) begin
                    if (emit) begin
                        load_out = 1'b1;
                        n_olast  = last_idx && !low_now && (i_rd_data == i_cfg.end_stop);
                        n_cur    = i_rd_data;
                        n_total  = total_next;
                        n_any    = 1'b1;
                    end
                    if (last_idx) begin
                        n_state = S_END;
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = r_idx + 1'b1;
                        n_idx           = r_idx + 1'b1;
                    end
                end
            end
            S_END: begin
                if (r_cur != i_cfg.end_stop) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_ocyl   = i_cfg.end_stop;
                        n_okind  = sds_pkg::KIND_END;
                        n_olast  = !r_low;
                        n_cur    = i_cfg.end_stop;
                        n_total  = total_next;
                        n_any    = 1'b1;
                        go_next  = 1'b1;
                    end
                end else if (!r_low && !r_any) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_ocyl   = i_cfg.head;
                        n_odist  = '0;
                        n_ototal = '0;
                        n_okind  = sds_pkg::KIND_NOMOVE;
                        n_olast  = 1'b1;
                        go_next  = 1'b1;
                    end
                end else begin
                    go_next = 1'b1;
                end
                if (go_next) begin
                    if (r_low) begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = count_m1;
                        n_idx           = count_m1;
                        n_state         = S_DESC;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_DESC: begin
                emit = (i_rd_data < i_cfg.head);
                if (!emit || out_free) begin
                    if (emit) begin
                        load_out = 1'b1;
                        n_olast  = (r_idx == '0);
                        n_cur    = i_rd_data;
                        n_total  = total_next;
                    end
                    if (r_idx == '0) begin
                        n_state = S_FIN;
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr       = r_idx - 1'b1;
                        n_idx           = r_idx - 1'b1;
                    end
                end
            end
            S_FIN: begin
                n_count = '0;
                n_ovf   = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_low    <= 1'b0;
            r_any    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_low   <= n_low;
            r_any   <= n_any;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_idx   <= n_idx;
        r_cur   <= n_cur;
        r_total <= n_total;
        if (load_out) begin
            r_ocyl   <= n_ocyl;
            r_odist  <= n_odist;
            r_ototal <= n_ototal;
            r_okind  <= n_okind;
            r_olast  <= n_olast;
            r_odrop  <= r_ovf;
        end
    end

    assign o_valid            = r_ovalid;
    assign o_visited_cylinder = r_ocyl;
    assign o_move_distance    = r_odist;
    assign o_total_seek       = r_ototal;
    assign o_kind             = r_okind;
    assign o_dropped          = r_odrop;
    assign o_last             = r_olast;

endmodule

// ----- rtl/core/scan_disk_scheduler_top.sv -----
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_op, i_cylinder
// result    out        o_valid / i_stall   o_visited_cylinder, o_move_distance,
//                                          o_total_seek, o_kind, o_dropped, o_last
// config    in         apb psel/penable    head_position at 0x0, disk_cylinders at 0x4
//
// a load into an empty store writes directly and one into a full store is dropped; else
// it shifts each larger entry up in the store memory (one read, one write per cycle)
// a run accepts, walks the stored requests upward, moves to the end stop, walks them
// downward again when any lies below the head, and clears the store
// results leave through a register
// a stalled result holds its register and pauses the run at the next result to emit
// synchronous reset empties the store count and drops any pending result
module scan_disk_scheduler_top #(
    parameter int MAX_REQUESTS = sds_pkg::MAX_REQUESTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [sds_pkg::CYL_W-1:0]   i_cylinder,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [sds_pkg::CYL_W-1:0]   o_visited_cylinder,
    output logic [sds_pkg::DIST_W-1:0]  o_move_distance,
    output logic [sds_pkg::TOTAL_W-1:0] o_total_seek,
    output logic [sds_pkg::KIND_W-1:0]  o_kind,
    output logic                        o_dropped,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sds_pkg::ADDR_W-1:0]  paddr,
    input  logic [sds_pkg::DATA_W-1:0]  pwdata,
    output logic [sds_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);

    sds_pkg::t_cfg             cfg;
    sds_pkg::t_mem_ctl         mem_ctl;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             wr_addr;
    logic [sds_pkg::CYL_W-1:0] wr_data;
    logic [sds_pkg::CYL_W-1:0] rd_data;

    sds_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sds_store #(
        .DEPTH (MAX_REQUESTS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    sds_seq #(
        .MAX_REQ (MAX_REQUESTS),
        .AW      (AW),
        .CW      (CW)
    ) u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_op               (i_op),
        .i_cylinder         (i_cylinder),
        .i_cfg              (cfg),
        .o_mem_ctl          (mem_ctl),
        .o_rd_addr          (rd_addr),
        .o_wr_addr          (wr_addr),
        .o_wr_data          (wr_data),
        .i_rd_data          (rd_data),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_visited_cylinder (o_visited_cylinder),
        .o_move_distance    (o_move_distance),
        .o_total_seek       (o_total_seek),
        .o_kind             (o_kind),
        .o_dropped          (o_dropped),
        .o_last             (o_last)
    );

endmodule

// ----- rtl/core/sds_checker.sv -----
`include "scan_disk_scheduler_top_macros.svh"

module sds_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [sds_pkg::CYL_W-1:0]   o_visited_cylinder,
    input logic [sds_pkg::DIST_W-1:0]  o_move_distance,
    input logic [sds_pkg::TOTAL_W-1:0] o_total_seek,
    input logic [sds_pkg::KIND_W-1:0]  o_kind,
    input logic                        o_last
);

    `SDS_ASSERT_ALWAYS(a_no_result_after_reset, i_clk, !i_rst_n |=> !o_valid)

    `SDS_ASSERT(a_stalled_result_held, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_visited_cylinder) && $stable(o_total_seek))

    `SDS_ASSERT(a_nomove_alone, i_clk, i_rst_n, o_valid && (o_kind == sds_pkg::KIND_NOMOVE) |-> o_last && (o_move_distance == '0) && (o_total_seek == '0))

    `SDS_ASSERT(a_seek_grows, i_clk, i_rst_n, o_valid && !i_stall && !o_last ##1 o_valid |-> o_total_seek == $past(o_total_seek) + sds_pkg::TOTAL_W'(o_move_distance))

endmodule

bind scan_disk_scheduler_top sds_checker u_sds_checker (.*);
